// ===== rtl/sos_pkg.sv =====
// sos_pkg: shared types and constants for the separator split core.
// Holds the result record, configuration register codes and port widths.
// No dependencies.
`default_nettype none

package sos_pkg;

	localparam int MAX_SEP_BYTES_DEF = 16;
	localparam longint unsigned MAX_STRING_BYTES_DEF = 64'd65535;

	// separator bytes held in the configuration registers
	localparam int SEP_REG_BYTES = 16;

	localparam int SEP_LEN_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 2;
	localparam int FIELD_W    = 16;

	// results one input beat can cause
	localparam int RES_SLOTS = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEP_LENGTH = 2'd0,
		REG_SEP_LOW    = 2'd1,
		REG_SEP_HIGH   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               last_piece;
		logic               too_long;
		logic               piece_valid;
		logic [FIELD_W-1:0] piece_length;
		logic [FIELD_W-1:0] piece_start;
	} piece_t;

endpackage

`default_nettype wire

// ===== rtl/split_on_separator_core.sv =====
// split_on_separator_core: splits a byte stream at separator matches and
// reports each piece as start offset and length. Uses sos_pkg.
//
//  channel  dir  fields
//  s_axis   in   tdata[7:0] data_byte, tuser[0] has_byte, tlast last_byte
//  m_axis   out  tdata[15:0] piece_start, [31:16] piece_length,
//                tuser[0] piece_valid, [1] too_long, tlast last_piece
//  cfg      in   cfg_index 0 sep_length, 1 sep_bytes_low, 2 sep_bytes_high
//
// An input beat is taken into a one-beat input register, compared against
// the reversed separator and written as up to three results into the result
// register, from which its first result is shown. Input beats go at one per
// cycle while the result register is free; the output drains one result per
// cycle while m_axis_tready is high, so a multi-result beat holds the input
// until its last result drains. Reset clears the handshake and string state;
// a separator write passes the configuration and reversed-separator registers.
`default_nettype none

module split_on_separator_core #(
	parameter int              MAX_SEP_BYTES    = sos_pkg::MAX_SEP_BYTES_DEF,
	parameter longint unsigned MAX_STRING_BYTES = sos_pkg::MAX_STRING_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [sos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sos_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [sos_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  wire logic [sos_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [0] has_byte
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [sos_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // piece_start, piece_length
	output logic [sos_pkg::OUT_USER_W-1:0]         m_axis_tuser,  // piece_valid, too_long
	output logic                                   m_axis_tlast
);
	import sos_pkg::*;

	localparam int WIN    = (MAX_SEP_BYTES > 1) ? MAX_SEP_BYTES - 1 : 1;
	localparam int LEN_CAP = (MAX_SEP_BYTES < 31) ? MAX_SEP_BYTES : 31;
	localparam int POS_W  = $clog2(MAX_STRING_BYTES + 64'd2);
	localparam int POSX_W = POS_W + 1;
	localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_STRING_BYTES);
	localparam logic [POS_W-1:0] OVER_POS = POS_W'(MAX_STRING_BYTES + 64'd1);

	// configuration registers
	logic [SEP_LEN_W-1:0]  sep_length_q;
	logic [CFG_DATA_W-1:0] sep_low_q;
	logic [CFG_DATA_W-1:0] sep_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_length_q <= '0;
			sep_low_q    <= '0;
			sep_high_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SEP_LENGTH: sep_length_q <= cfg_wdata[SEP_LEN_W-1:0];
				REG_SEP_LOW:    sep_low_q    <= cfg_wdata;
				REG_SEP_HIGH:   sep_high_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamped length and separator reversed so lane 0 meets the newest byte
	logic [SEP_LEN_W-1:0] len_eff;
	logic [SEP_LEN_W-1:0] len_q;
	logic [7:0]           sep_arr [SEP_REG_BYTES];
	logic [7:0]           rev_sep_n [MAX_SEP_BYTES];
	logic [7:0]           rev_sep_q [MAX_SEP_BYTES];
	logic [MAX_SEP_BYTES-1:0] lane_en_n;
	logic [MAX_SEP_BYTES-1:0] lane_en_q;

	assign len_eff = (int'(sep_length_q) > LEN_CAP) ? SEP_LEN_W'(LEN_CAP) : sep_length_q;

	always_comb begin
		for (int i = 0; i < SEP_REG_BYTES / 2; i++) begin
			sep_arr[i]                     = sep_low_q[i*8 +: 8];
			sep_arr[i + SEP_REG_BYTES / 2] = sep_high_q[i*8 +: 8];
		end
	end

	always_comb begin
		int j;
		for (int k = 0; k < MAX_SEP_BYTES; k++) begin
			j = int'(len_eff) - 1 - k;
			lane_en_n[k] = (k < int'(len_eff));
			if (lane_en_n[k] && j < SEP_REG_BYTES) begin
				rev_sep_n[k] = sep_arr[4'(j)];
			end else begin
				rev_sep_n[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			lane_en_q <= '0;
		end else begin
			len_q     <= len_eff;
			lane_en_q <= lane_en_n;
		end
	end

	always_ff @(posedge clk) begin
		rev_sep_q <= rev_sep_n;
	end

	// input register
	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 has_s1;
	logic                 last_s1;
	logic                 in_hs;
	logic                 adv_s1;
	logic                 free_s2;

	assign in_hs         = s_axis_tvalid && s_axis_tready;
	assign adv_s1        = valid_s1 && free_s2;
	assign s_axis_tready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_hs) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_hs) begin
			data_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser[0];
			last_s1 <= s_axis_tlast;
		end
	end

	// string state
	logic [7:0]       win_q [WIN];
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] begin_q;
	logic             start_q;

	// window compare
	logic [MAX_SEP_BYTES-1:0] lane_ok;
	logic                     match;

	always_comb begin
		for (int k = 0; k < MAX_SEP_BYTES; k++) begin
			if (k == 0) begin
				lane_ok[k] = !lane_en_q[k] || (data_s1 == rev_sep_q[k]);
			end else begin
				lane_ok[k] = !lane_en_q[k] || (win_q[k-1] == rev_sep_q[k]);
			end
		end
	end

	assign match = &lane_ok;

	// step logic
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] begin_n;
	logic             start_n;
	logic [POS_W-1:0] p1;
	logic [POS_W-1:0] len_ext;
	logic [POS_W-1:0] total;
	logic             shift_en;
	logic             lead_v;
	logic             mid_v;
	logic             fin_v;
	piece_t           lead_r;
	piece_t           mid_r;
	piece_t           fin_r;

	assign p1      = pos_q + POS_W'(1);
	assign len_ext = POS_W'(len_q);

	always_comb begin
		pos_n    = pos_q;
		begin_n  = begin_q;
		start_n  = start_q;
		shift_en = 1'b0;
		lead_v   = 1'b0;
		mid_v    = 1'b0;
		fin_v    = 1'b0;
		total    = '0;
		lead_r   = '{last_piece: 1'b0, too_long: 1'b0, piece_valid: 1'b1,
			piece_length: '0, piece_start: '0};
		mid_r    = '{last_piece: 1'b0, too_long: 1'b0, piece_valid: 1'b1,
			piece_length: '0, piece_start: FIELD_W'(begin_q)};
		fin_r    = '{last_piece: 1'b1, too_long: 1'b0, piece_valid: 1'b1,
			piece_length: '0, piece_start: '0};

		if (has_s1) begin
			if (pos_q < MAX_POS) begin
				if (len_q == '0) begin
					lead_v             = start_q;
					mid_v              = 1'b1;
					mid_r.piece_length = FIELD_W'(p1 - begin_q);
					begin_n            = p1;
				end else if (p1 >= len_ext &&
						{1'b0, p1} >= ({1'b0, begin_q} + POSX_W'(len_q)) && match) begin
					mid_v              = 1'b1;
					mid_r.piece_length = FIELD_W'(p1 - len_ext - begin_q);
					begin_n            = p1;
				end
				shift_en = 1'b1;
				pos_n    = p1;
			end else begin
				// drop bytes past the length bound
				pos_n = OVER_POS;
			end
			start_n = 1'b0;
		end

		if (last_s1) begin
			total          = (pos_n > MAX_POS) ? MAX_POS : pos_n;
			fin_v          = 1'b1;
			fin_r.too_long = (pos_n > MAX_POS);
			if (len_q != '0 && total < len_ext) begin
				fin_r.piece_valid = 1'b0;
			end else begin
				if (len_q == '0 && start_n) begin
					lead_v = 1'b1;
				end
				fin_r.piece_start  = FIELD_W'(begin_n);
				fin_r.piece_length = FIELD_W'(total - begin_n);
			end
			pos_n   = '0;
			begin_n = '0;
			start_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			begin_q <= '0;
			start_q <= 1'b1;
		end else if (adv_s1) begin
			pos_q   <= pos_n;
			begin_q <= begin_n;
			start_q <= start_n;
		end
	end

	// window needs no clear: a match needs as many bytes of this string
	always_ff @(posedge clk) begin
		if (adv_s1 && shift_en) begin
			win_q[0] <= data_s1;
			for (int i = 1; i < WIN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	// result register: up to three results, drained lowest slot first
	piece_t               res_s2 [RES_SLOTS];
	logic [RES_SLOTS-1:0] mask_s2;
	logic [RES_SLOTS-1:0] mask_clr;
	logic                 out_hs;
	piece_t               out_r;

	assign out_hs   = m_axis_tvalid && m_axis_tready;
	assign mask_clr = mask_s2 & (mask_s2 - RES_SLOTS'(1));
	assign free_s2  = (mask_s2 == '0) || (out_hs && mask_clr == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (adv_s1) begin
			mask_s2 <= {fin_v, mid_v, lead_v};
		end else if (out_hs) begin
			mask_s2 <= mask_clr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2[0] <= lead_r;
			res_s2[1] <= mid_r;
			res_s2[2] <= fin_r;
		end
	end

	always_comb begin
		priority if (mask_s2[0]) begin
			out_r = res_s2[0];
		end else if (mask_s2[1]) begin
			out_r = res_s2[1];
		end else begin
			out_r = res_s2[2];
		end
	end

	assign m_axis_tvalid = (mask_s2 != '0);
	assign m_axis_tdata  = {out_r.piece_length, out_r.piece_start};
	assign m_axis_tuser  = {out_r.too_long, out_r.piece_valid};
	assign m_axis_tlast  = out_r.last_piece;

endmodule

`default_nettype wire

// ===== dv/tb_split_on_separator_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for split_on_separator_core: queued byte beats, a piece predictor
// updated on each accepted beat, and a result monitor that checks every field in order.
// Depends on rtl/sos_pkg.sv and rtl/split_on_separator_core.sv.

module tb_split_on_separator_core;
	import sos_pkg::*;

	localparam int unsigned SEP_CAP      = MAX_SEP_BYTES_DEF;
	localparam int unsigned STR_CAP      = 32'(MAX_STRING_BYTES_DEF);
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES  = 120;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       ends;
	} byte_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [IN_USER_W-1:0]   s_axis_tuser = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [OUT_USER_W-1:0]  m_axis_tuser;
	logic                   m_axis_tlast;

	// predictor copy of registers and string state
	logic [4:0]  sep_len_reg = '0;
	logic [63:0] sep_lo_reg = '0;
	logic [63:0] sep_hi_reg = '0;
	logic [7:0]  tail_bytes [0:SEP_CAP-2];
	int unsigned str_pos = 0;
	int unsigned piece_beg = 0;
	bit          str_fresh = 1'b1;

	byte_beat_t  byte_beats [$];
	piece_t      due_pieces [$];
	byte_beat_t  drv_beat;
	piece_t      want;

	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned hold_at_beat = 32'hFFFF_FFFF;
	int unsigned beats_accepted = 0;
	int unsigned strings_done = 0;
	int unsigned pieces_seen = 0;
	int unsigned errors = 0;

	split_on_separator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // [7:0] data_byte
		.s_axis_tuser  (s_axis_tuser),  // [0] has_byte
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // [15:0] piece_start, [31:16] piece_length
		.m_axis_tuser  (m_axis_tuser),  // [0] piece_valid, [1] too_long
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("%0t: timeout, %0d pieces still due", $time, due_pieces.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned pause_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic void add_piece(input int unsigned start, input int unsigned plen,
			input bit ok, input bit fin);
		piece_t pc;
		pc.piece_start  = start[15:0];
		pc.piece_length = plen[15:0];
		pc.piece_valid  = ok;
		pc.too_long     = (str_pos > STR_CAP);
		pc.last_piece   = fin;
		due_pieces.push_back(pc);
	endfunction

	function automatic void predict_pieces(input logic [7:0] data, input logic has,
			input logic fin);
		int unsigned n_sep, p, total, k;
		logic [127:0] sep_all;
		logic [7:0] b;
		bit hit;
		n_sep = (sep_len_reg > SEP_CAP) ? SEP_CAP : sep_len_reg;
		sep_all = {sep_hi_reg, sep_lo_reg};
		if (has) begin
			if (str_pos < STR_CAP) begin
				p = str_pos;
				if (n_sep == 0) begin
					if (str_fresh)
						add_piece(0, 0, 1'b1, 1'b0);
					add_piece(piece_beg, p + 1 - piece_beg, 1'b1, 1'b0);
					piece_beg = p + 1;
				end else if (p + 1 >= n_sep && p + 1 - n_sep >= piece_beg) begin
					// newest byte against the last separator byte, back to the first
					hit = 1'b1;
					for (k = 0; k < n_sep; k++) begin
						b = (k == 0) ? data : tail_bytes[k-1];
						if (b != sep_all[8*(n_sep-1-k) +: 8])
							hit = 1'b0;
					end
					if (hit) begin
						add_piece(piece_beg, p + 1 - n_sep - piece_beg, 1'b1, 1'b0);
						piece_beg = p + 1;
					end
				end
				for (k = SEP_CAP - 2; k > 0; k--)
					tail_bytes[k] = tail_bytes[k-1];
				tail_bytes[0] = data;
				str_pos = p + 1;
			end else begin
				// past the bound: drop the byte, remember the overflow
				str_pos = STR_CAP + 1;
			end
			str_fresh = 1'b0;
		end
		if (fin) begin
			total = (str_pos > STR_CAP) ? STR_CAP : str_pos;
			if (n_sep != 0 && total < n_sep) begin
				add_piece(0, 0, 1'b0, 1'b1);
			end else begin
				if (n_sep == 0 && str_fresh)
					add_piece(0, 0, 1'b1, 1'b0);
				add_piece(piece_beg, total - piece_beg, 1'b1, 1'b1);
			end
			foreach (tail_bytes[i])
				tail_bytes[i] = 8'h00;
			str_pos = 0;
			piece_beg = 0;
			str_fresh = 1'b1;
			strings_done++;
		end
	endfunction

	task automatic check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	// driver: one beat per handshake, random gaps after beats when tx idling is enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_pieces(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
				beats_accepted <= beats_accepted + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (byte_beats.size() != 0) begin
					drv_beat = byte_beats.pop_front();
					s_axis_tdata <= drv_beat.data;
					s_axis_tuser <= drv_beat.has;
					s_axis_tlast <= drv_beat.ends;
					s_axis_tvalid <= 1'b1;
					gap_left <= (tx_idle_en && $urandom_range(0, 99) < 35) ? pause_len() : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: one long hold early in the random part, random stalls when rx idling is enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && beats_accepted == hold_at_beat) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
			stall_left <= pause_len() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pieces_seen++;
			if (due_pieces.size() == 0) begin
				$display("%0t: piece with none due, expected nothing, actual start %0d len %0d",
					$time, m_axis_tdata[15:0], m_axis_tdata[31:16]);
				errors++;
			end else begin
				want = due_pieces.pop_front();
				check_field("piece_start", want.piece_start, m_axis_tdata[15:0]);
				check_field("piece_length", want.piece_length, m_axis_tdata[31:16]);
				check_field("piece_valid", want.piece_valid, m_axis_tuser[0]);
				check_field("too_long", want.too_long, m_axis_tuser[1]);
				check_field("last_piece", want.last_piece, m_axis_tlast);
			end
		end
	end

	task automatic add_beat(input logic [7:0] data, input logic has, input logic fin);
		byte_beat_t bt;
		bt.data = data;
		bt.has = has;
		bt.ends = fin;
		byte_beats.push_back(bt);
	endtask

	// wait until every beat is taken and every piece is back, then let the pipe drain
	task automatic settle();
		do @(negedge clk);
		while (byte_beats.size() != 0 || s_axis_tvalid || due_pieces.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SEP_LENGTH: sep_len_reg = val[4:0];
			REG_SEP_LOW:    sep_lo_reg = val;
			default:        sep_hi_reg = val;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic new_phase(input int unsigned n, input logic [63:0] lo, input logic [63:0] hi,
			input bit tx_on, input bit rx_on);
		logic [63:0] lv;
		settle();
		// junk above bit 4 must be ignored
		lv = rnd64();
		lv[4:0] = n[4:0];
		write_reg(REG_SEP_LENGTH, lv);
		write_reg(REG_SEP_LOW, lo);
		write_reg(REG_SEP_HIGH, hi);
		@(negedge clk);
		tx_idle_en = tx_on;
		rx_idle_en = rx_on;
	endtask

	// strings built from separator copies (some broken), separator bytes and noise
	task automatic push_strings(input int unsigned n_items);
		int unsigned cnt, slen, n_sep, j, r, idx;
		bit sep_end;
		logic [127:0] sep_all;
		logic [7:0] alpha [0:3];
		logic [7:0] body [$];
		cnt = 0;
		n_sep = (sep_len_reg > SEP_CAP) ? SEP_CAP : sep_len_reg;
		sep_all = {sep_hi_reg, sep_lo_reg};
		alpha[0] = sep_all[7:0];
		alpha[1] = sep_all[15:8];
		alpha[2] = (n_sep != 0) ? sep_all[8*(n_sep-1) +: 8] : 8'h2C;
		alpha[3] = 8'($urandom);
		while (cnt < n_items) begin
			body.delete();
			slen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
			while (body.size() < slen) begin
				r = $urandom_range(0, 99);
				if (n_sep != 0 && r < 25) begin
					for (j = 0; j < n_sep; j++)
						body.push_back(sep_all[8*j +: 8]);
					if (r < 5) begin
						idx = body.size() - 1 - $urandom_range(0, n_sep - 1);
						body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
					end
				end else if (r < 85) begin
					body.push_back(alpha[$urandom_range(0, 3)]);
				end else begin
					body.push_back(8'($urandom));
				end
			end
			sep_end = (body.size() == 0) || ($urandom_range(0, 3) == 0);
			foreach (body[i]) begin
				if ($urandom_range(0, 19) == 0)
					add_beat(8'($urandom), 1'b0, 1'b0);
				add_beat(body[i], 1'b1, (i == body.size() - 1) && !sep_end);
			end
			if (sep_end)
				add_beat(8'($urandom), 1'b0, 1'b1);
			cnt += body.size() + sep_end;
		end
		// leave a string open across the next register change now and then
		if ($urandom_range(0, 2) == 0) begin
			slen = $urandom_range(1, 4);
			for (j = 0; j < slen; j++)
				add_beat(alpha[$urandom_range(0, 3)], 1'b1, 1'b0);
		end
	endtask

	initial begin
		logic [63:0] lo;
		foreach (tail_bytes[i])
			tail_bytes[i] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// per-byte split: empty string, ignored beat, extremes, end without a byte
		new_phase(0, rnd64(), rnd64(), 1'b1, 1'b1);
		add_beat(8'h00, 1'b0, 1'b1);
		add_beat(8'($urandom), 1'b0, 1'b0);
		add_beat(8'h00, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b1);
		add_beat(8'hA5, 1'b1, 1'b0);
		add_beat(8'h00, 1'b0, 1'b1);

		// two-byte separator: short string, back-to-back matches, string left open
		lo = rnd64();
		lo[15:0] = 16'h202C;
		new_phase(2, lo, rnd64(), 1'b1, 1'b1);
		add_beat(8'h78, 1'b1, 1'b1);
		add_beat(8'h2C, 1'b1, 1'b0);
		add_beat(8'h20, 1'b1, 1'b0);
		add_beat(8'h2C, 1'b1, 1'b0);
		add_beat(8'h20, 1'b1, 1'b0);
		add_beat(8'h62, 1'b1, 1'b0);
		add_beat(8'h2C, 1'b1, 1'b0);

		// switch to per-byte mid-string: no leading empty piece
		new_phase(0, rnd64(), rnd64(), 1'b0, 1'b1);
		add_beat(8'h20, 1'b1, 1'b0);
		add_beat(8'h71, 1'b1, 1'b1);

		// oversized length acts as the full separator: short strings give only an invalid last piece
		new_phase(31, '1, '1, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b0, 1'b1);
		add_beat(8'hFF, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b1);

		new_phase(1, rnd64(), rnd64(), 1'b1, 1'b1);
		hold_at_beat = beats_accepted + 8;
		push_strings(24);
		new_phase(3, rnd64(), rnd64(), 1'b1, 1'b0);
		push_strings(24);
		new_phase(0, rnd64(), rnd64(), 1'b0, 1'b0);
		push_strings(24);
		new_phase(16, rnd64(), rnd64(), 1'b1, 1'b1);
		push_strings(24);
		new_phase($urandom_range(17, 31), rnd64(), rnd64(), 1'b0, 1'b1);
		push_strings(24);
		new_phase($urandom_range(2, 8), rnd64(), rnd64(), 1'b1, 1'b1);
		push_strings(24);

		settle();
		$display("Ran %0d byte beats forming %0d strings; %0d pieces compared.",
			beats_accepted, strings_done, pieces_seen);
		$display("Separator lengths 0 to 31, open strings across changes, long output hold.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
